/* hdl/qrs_pkg.sv */
package qrs_pkg;

  localparam int KIND_W = 3;
  localparam int DISC_W = 34;
  localparam int ROOT_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_INFINITE = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_TWO      = 3'd4
  } kind_t;

endpackage

/* hdl/qrs_sqrt_cell.sv */
module qrs_sqrt_cell #(
  parameter int RADW = 66,
  parameter int SW   = 33,
  parameter int SBW  = 85
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic [RADW-1:0]     rad,
  input  logic [SW+1:0]       rem,
  input  logic [SW-1:0]       root,
  input  logic [SBW-1:0]      sb,
  output logic                valid_fwd,
  output logic [RADW-1:0]     rad_fwd,
  output logic [SW+1:0]       rem_fwd,
  output logic [SW-1:0]       root_fwd,
  output logic [SBW-1:0]      sb_fwd
);

  localparam int RMW = SW + 2;

  logic [RMW+1:0] rem_sh;
  logic [RMW+1:0] trial;
  logic           ge;
  logic [RMW-1:0] rem_next;
  logic [SW-1:0]  root_next;

  // one root bit per cell, two radicand bits consumed
  always_comb begin
    rem_sh    = {rem, rad[RADW-1 -: 2]};
    trial     = (RMW+2)'({root, 2'b01});
    ge        = (rem_sh >= trial);
    rem_next  = ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
    root_next = {root[SW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_fwd <= 1'b0;
    end else begin
      valid_fwd <= valid;
    end
  end

  always_ff @(posedge clk) begin
    rad_fwd  <= {rad[RADW-3:0], 2'b00};
    rem_fwd  <= rem_next;
    root_fwd <= root_next;
    sb_fwd   <= sb;
  end

endmodule

/* hdl/qrs_div_cell.sv */
module qrs_div_cell #(
  parameter int NW  = 35,
  parameter int DMW = 17,
  parameter int SBW = 39
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             valid,
  input  logic [DMW-1:0]   den,
  input  logic [NW-1:0]    nq1,
  input  logic [DMW-1:0]   r1,
  input  logic [NW-1:0]    nq2,
  input  logic [DMW-1:0]   r2,
  input  logic [SBW-1:0]   sb,
  output logic             valid_fwd,
  output logic [DMW-1:0]   den_fwd,
  output logic [NW-1:0]    nq1_fwd,
  output logic [DMW-1:0]   r1_fwd,
  output logic [NW-1:0]    nq2_fwd,
  output logic [DMW-1:0]   r2_fwd,
  output logic [SBW-1:0]   sb_fwd
);

  logic [DMW:0] t1;
  logic [DMW:0] t2;
  logic [DMW:0] den_x;
  logic         ge1;
  logic         ge2;

  // restoring step: numerator bits shift out the top, quotient bits shift in below
  always_comb begin
    den_x = {1'b0, den};
    t1    = {r1, nq1[NW-1]};
    t2    = {r2, nq2[NW-1]};
    ge1   = (t1 >= den_x);
    ge2   = (t2 >= den_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_fwd <= 1'b0;
    end else begin
      valid_fwd <= valid;
    end
  end

  always_ff @(posedge clk) begin
    den_fwd <= den;
    r1_fwd  <= ge1 ? DMW'(t1 - den_x) : DMW'(t1);
    r2_fwd  <= ge2 ? DMW'(t2 - den_x) : DMW'(t2);
    nq1_fwd <= {nq1[NW-2:0], ge1};
    nq2_fwd <= {nq2[NW-2:0], ge2};
    sb_fwd  <= sb;
  end

endmodule

/* hdl/quadratic_root_solver.sv */
// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+-----------------------
// command   | coef_quad, coef_lin, coef_const                   | start & !busy
// result    | root_kind, discriminant, root_plus, root_minus    | done, one cycle
//
// one transaction enters per clock; busy is never raised
// a transaction passes the product and classification registers, the square-root
// cell row (one root bit per cell), the numerator register and the divider
// cell row (one quotient bit per cell) on its way to the result register
// rst clears the valid bits of every stage; results cannot be stalled
module quadratic_root_solver #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COEF_BITS-1:0]         coef_quad,
  input  logic signed [COEF_BITS-1:0]         coef_lin,
  input  logic signed [COEF_BITS-1:0]         coef_const,
  output logic                                done,
  output logic [qrs_pkg::KIND_W-1:0]          root_kind,
  output logic signed [qrs_pkg::DISC_W-1:0]   discriminant,
  output logic signed [qrs_pkg::ROOT_W-1:0]   root_plus,
  output logic signed [qrs_pkg::ROOT_W-1:0]   root_minus
);

  localparam int CW   = COEF_BITS;
  localparam int FW   = FRAC_BITS;
  localparam int KW   = qrs_pkg::KIND_W;
  localparam int DW   = 2*CW + 2;
  localparam int SQN  = CW + 1 + FW;
  localparam int RADW = 2*SQN;
  localparam int NW   = SQN + 2;
  localparam int DMW  = CW + 1;
  localparam int SB1  = KW + DW + 3*CW;
  localparam int SB2  = KW + DW + 2;

  assign busy = 1'b0;

  // products
  logic                   v1;
  logic signed [CW-1:0]   a1, b1, c1;
  logic signed [2*CW-1:0] bb1, ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a1  <= coef_quad;
    b1  <= coef_lin;
    c1  <= coef_const;
    bb1 <= coef_lin * coef_lin;
    ac1 <= coef_quad * coef_const;
  end

  // discriminant and classification
  logic signed [DW-1:0]   disc_w;
  qrs_pkg::kind_t         kind_w;
  logic                   v2;
  qrs_pkg::kind_t         kind2;
  logic signed [DW-1:0]   disc2;
  logic signed [CW-1:0]   a2, b2, c2;

  always_comb begin
    disc_w = DW'(bb1) - (DW'(ac1) <<< 2);
    if (a1 == '0) begin
      if (b1 == '0) begin
        kind_w = (c1 == '0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NONE;
      end else begin
        kind_w = qrs_pkg::KIND_LINEAR;
      end
    end else if (disc_w < 0) begin
      kind_w = qrs_pkg::KIND_NONE;
    end else if (disc_w == '0) begin
      kind_w = qrs_pkg::KIND_DOUBLE;
    end else begin
      kind_w = qrs_pkg::KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    kind2 <= kind_w;
    disc2 <= (a1 == '0) ? '0 : disc_w;
    a2    <= a1;
    b2    <= b1;
    c2    <= c1;
  end

  // square-root cell row
  logic            sq_v   [0:SQN];
  logic [RADW-1:0] sq_rad [0:SQN];
  logic [SQN+1:0]  sq_rem [0:SQN];
  logic [SQN-1:0]  sq_root[0:SQN];
  logic [SB1-1:0]  sq_sb  [0:SQN];

  assign sq_v[0]    = v2;
  assign sq_rad[0]  = (kind2 == qrs_pkg::KIND_TWO) ? {disc2, {(2*FW){1'b0}}} : '0;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = {kind2, disc2, a2, b2, c2};

  for (genvar i = 0; i < SQN; i++) begin : g_sqrt
    qrs_sqrt_cell #(
      .RADW (RADW),
      .SW   (SQN),
      .SBW  (SB1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid     (sq_v[i]),
      .rad       (sq_rad[i]),
      .rem       (sq_rem[i]),
      .root      (sq_root[i]),
      .sb        (sq_sb[i]),
      .valid_fwd (sq_v[i+1]),
      .rad_fwd   (sq_rad[i+1]),
      .rem_fwd   (sq_rem[i+1]),
      .root_fwd  (sq_root[i+1]),
      .sb_fwd    (sq_sb[i+1])
    );
  end

  // numerators and denominator
  qrs_pkg::kind_t         kind3;
  logic signed [DW-1:0]   disc3;
  logic signed [CW-1:0]   a3, b3, c3;
  logic signed [NW-1:0]   s_x, nb, nc, n1, n2;
  logic signed [DMW-1:0]  den_s;
  logic [NW-1:0]          n1m, n2m;
  logic [DMW-1:0]         denm;

  always_comb begin
    kind3 = qrs_pkg::kind_t'(sq_sb[SQN][SB1-1 -: KW]);
    disc3 = sq_sb[SQN][3*CW +: DW];
    a3    = sq_sb[SQN][2*CW +: CW];
    b3    = sq_sb[SQN][CW +: CW];
    c3    = sq_sb[SQN][0 +: CW];
    s_x   = signed'(NW'(sq_root[SQN]));
    nb    = -(NW'(b3) <<< FW);
    nc    = -(NW'(c3) <<< FW);
    case (kind3)
      qrs_pkg::KIND_LINEAR: begin
        n1    = nc;
        n2    = '0;
        den_s = DMW'(b3);
      end
      qrs_pkg::KIND_DOUBLE: begin
        n1    = nb;
        n2    = '0;
        den_s = DMW'(a3) <<< 1;
      end
      qrs_pkg::KIND_TWO: begin
        n1    = nb + s_x;
        n2    = nb - s_x;
        den_s = DMW'(a3) <<< 1;
      end
      default: begin
        n1    = '0;
        n2    = '0;
        den_s = DMW'(1);
      end
    endcase
    n1m  = n1[NW-1] ? NW'(-n1) : NW'(n1);
    n2m  = n2[NW-1] ? NW'(-n2) : NW'(n2);
    denm = den_s[DMW-1] ? DMW'(-den_s) : DMW'(den_s);
  end

  logic           v4;
  logic [NW-1:0]  n1m4, n2m4;
  logic [DMW-1:0] denm4;
  logic [SB2-1:0] sb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= sq_v[SQN];
    end
  end

  always_ff @(posedge clk) begin
    n1m4  <= n1m;
    n2m4  <= n2m;
    denm4 <= denm;
    sb4   <= {kind3, disc3, n1[NW-1] ^ den_s[DMW-1], n2[NW-1] ^ den_s[DMW-1]};
  end

  // divider cell row
  logic           dv_v  [0:NW];
  logic [DMW-1:0] dv_den[0:NW];
  logic [NW-1:0]  dv_nq1[0:NW];
  logic [DMW-1:0] dv_r1 [0:NW];
  logic [NW-1:0]  dv_nq2[0:NW];
  logic [DMW-1:0] dv_r2 [0:NW];
  logic [SB2-1:0] dv_sb [0:NW];

  assign dv_v[0]   = v4;
  assign dv_den[0] = denm4;
  assign dv_nq1[0] = n1m4;
  assign dv_r1[0]  = '0;
  assign dv_nq2[0] = n2m4;
  assign dv_r2[0]  = '0;
  assign dv_sb[0]  = sb4;

  for (genvar j = 0; j < NW; j++) begin : g_div
    qrs_div_cell #(
      .NW  (NW),
      .DMW (DMW),
      .SBW (SB2)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid     (dv_v[j]),
      .den       (dv_den[j]),
      .nq1       (dv_nq1[j]),
      .r1        (dv_r1[j]),
      .nq2       (dv_nq2[j]),
      .r2        (dv_r2[j]),
      .sb        (dv_sb[j]),
      .valid_fwd (dv_v[j+1]),
      .den_fwd   (dv_den[j+1]),
      .nq1_fwd   (dv_nq1[j+1]),
      .r1_fwd    (dv_r1[j+1]),
      .nq2_fwd   (dv_nq2[j+1]),
      .r2_fwd    (dv_r2[j+1]),
      .sb_fwd    (dv_sb[j+1])
    );
  end

  // sign fix and result register
  logic signed [NW:0]   q1s, q2s;
  logic signed [DW-1:0] disc5;
  logic [KW-1:0]        kind5;

  always_comb begin
    kind5 = dv_sb[NW][SB2-1 -: KW];
    disc5 = dv_sb[NW][2 +: DW];
    q1s   = dv_sb[NW][1] ? -signed'({1'b0, dv_nq1[NW]}) : signed'({1'b0, dv_nq1[NW]});
    q2s   = dv_sb[NW][0] ? -signed'({1'b0, dv_nq2[NW]}) : signed'({1'b0, dv_nq2[NW]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    root_kind    <= kind5;
    discriminant <= qrs_pkg::DISC_W'(disc5);
    root_plus    <= qrs_pkg::ROOT_W'(q1s);
    root_minus   <= qrs_pkg::ROOT_W'(q2s);
  end

endmodule
